// ===== design/pcp_pkg.sv =====
// Package for the PNG chunk stream parser: phase encoding, byte roles,
// the signature table and the per-item result record.
// Used by pcp_framer and png_chunk_stream_parser_unit; depends on nothing.
package pcp_pkg;

    // Byte role codes as seen on the result channel.
    localparam logic [2:0] ROLE_SIG     = 3'd0;
    localparam logic [2:0] ROLE_LEN     = 3'd1;
    localparam logic [2:0] ROLE_TYPE    = 3'd2;
    localparam logic [2:0] ROLE_DATA    = 3'd3;
    localparam logic [2:0] ROLE_CRC     = 3'd4;
    localparam logic [2:0] ROLE_DISCARD = 3'd5;

    // Default chunk type to flag: "IDAT", big-endian.
    localparam logic [31:0] TARGET_RESET = 32'h4944_4154;

    // Framing phase, one-hot.
    typedef enum logic [5:0] {
        PH_SIG     = 6'b000001,
        PH_LEN     = 6'b000010,
        PH_TYPE    = 6'b000100,
        PH_DATA    = 6'b001000,
        PH_CRC     = 6'b010000,
        PH_DISCARD = 6'b100000
    } phase_t;

    // Result of one item, handed from the framer to the output register.
    typedef struct packed {
        logic [2:0]  byte_role;
        logic        in_target;
        logic        last_of_chunk;
        logic        signature_ok;
        logic        signature_bad;
        logic [31:0] chunk_offset;
        logic [31:0] chunk_length;
    } result_t;

    // The eight PNG signature bytes.
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'h89;
            3'd1:    val = 8'h50;
            3'd2:    val = 8'h4E;
            3'd3:    val = 8'h47;
            3'd4:    val = 8'h0D;
            3'd5:    val = 8'h0A;
            3'd6:    val = 8'h1A;
            3'd7:    val = 8'h0A;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

// ===== design/pcp_framer.sv =====
// Framing state and next-state logic of the PNG chunk stream parser.
// Takes one byte per step and produces its result record combinationally.
// Depends on pcp_pkg.
module pcp_framer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       data_byte,
    input  logic             first_byte,
    input  logic             cfg_wr_en,
    input  logic [31:0]      cfg_wr_data,
    output pcp_pkg::result_t result
);

    pcp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  field_index_reg, field_index_next;
    logic [31:0] data_remaining_reg, data_remaining_next;
    logic [31:0] length_shift_reg, length_shift_next;
    logic [31:0] type_shift_reg, type_shift_next;
    logic [31:0] file_position_reg, file_position_next;
    logic [31:0] start_offset_reg, start_offset_next;
    logic        sig_match_reg, sig_match_next;
    logic        target_seen_reg, target_seen_next;
    logic        target_active_reg, target_active_next;
    logic [31:0] target_type_reg;

    // Next state and result for the byte being processed.
    always_comb begin
        phase_next          = phase_reg;
        field_index_next    = field_index_reg;
        data_remaining_next = data_remaining_reg;
        length_shift_next   = length_shift_reg;
        type_shift_next     = type_shift_reg;
        file_position_next  = file_position_reg;
        start_offset_next   = start_offset_reg;
        sig_match_next      = sig_match_reg;
        target_seen_next    = target_seen_reg;
        target_active_next  = target_active_reg;

        // A first byte restarts the file before it is handled.
        if (first_byte) begin
            phase_next          = pcp_pkg::PH_SIG;
            field_index_next    = 3'd0;
            data_remaining_next = 32'd0;
            length_shift_next   = 32'd0;
            type_shift_next     = 32'd0;
            file_position_next  = 32'd0;
            start_offset_next   = 32'd0;
            sig_match_next      = 1'b1;
            target_seen_next    = 1'b0;
            target_active_next  = 1'b0;
        end

        result = '0;

        case (phase_next)
            pcp_pkg::PH_SIG: begin
                result.byte_role = pcp_pkg::ROLE_SIG;
                if (data_byte != pcp_pkg::sig_byte(field_index_next)) begin
                    sig_match_next = 1'b0;
                end
                if (field_index_next == 3'd7) begin
                    field_index_next    = 3'd0;
                    phase_next          = sig_match_next ? pcp_pkg::PH_LEN
                                                         : pcp_pkg::PH_DISCARD;
                    result.signature_ok = sig_match_next;
                end else begin
                    field_index_next = field_index_next + 3'd1;
                end
            end
            pcp_pkg::PH_LEN: begin
                result.byte_role    = pcp_pkg::ROLE_LEN;
                result.signature_ok = 1'b1;
                if (field_index_next == 3'd0) begin
                    start_offset_next = file_position_next;
                end
                length_shift_next   = {length_shift_next[23:0], data_byte};
                result.chunk_offset = start_offset_next;
                if (field_index_next >= 3'd3) begin
                    field_index_next = 3'd0;
                    type_shift_next  = 32'd0;
                    phase_next       = pcp_pkg::PH_TYPE;
                end else begin
                    field_index_next = field_index_next + 3'd1;
                end
            end
            pcp_pkg::PH_TYPE: begin
                result.byte_role    = pcp_pkg::ROLE_TYPE;
                result.signature_ok = 1'b1;
                type_shift_next     = {type_shift_next[23:0], data_byte};
                result.chunk_offset = start_offset_next;
                result.chunk_length = length_shift_next;
                if (field_index_next >= 3'd3) begin
                    field_index_next = 3'd0;
                    if (type_shift_next == target_type_reg && !target_seen_next) begin
                        target_seen_next   = 1'b1;
                        target_active_next = 1'b1;
                    end
                    data_remaining_next = length_shift_next;
                    phase_next = (length_shift_next == 32'd0) ? pcp_pkg::PH_CRC
                                                              : pcp_pkg::PH_DATA;
                end else begin
                    field_index_next = field_index_next + 3'd1;
                end
                result.in_target = target_active_next;
            end
            pcp_pkg::PH_DATA: begin
                result.byte_role    = pcp_pkg::ROLE_DATA;
                result.signature_ok = 1'b1;
                result.chunk_offset = start_offset_next;
                result.chunk_length = length_shift_next;
                result.in_target    = target_active_next;
                data_remaining_next = data_remaining_next - 32'd1;
                if (data_remaining_next == 32'd0) begin
                    field_index_next = 3'd0;
                    phase_next       = pcp_pkg::PH_CRC;
                end
            end
            pcp_pkg::PH_CRC: begin
                result.byte_role    = pcp_pkg::ROLE_CRC;
                result.signature_ok = 1'b1;
                result.chunk_offset = start_offset_next;
                result.chunk_length = length_shift_next;
                result.in_target    = target_active_next;
                if (field_index_next >= 3'd3) begin
                    result.last_of_chunk = 1'b1;
                    field_index_next     = 3'd0;
                    length_shift_next    = 32'd0;
                    target_active_next   = 1'b0;
                    phase_next           = pcp_pkg::PH_LEN;
                end else begin
                    field_index_next = field_index_next + 3'd1;
                end
            end
            default: begin
                result.byte_role = pcp_pkg::ROLE_DISCARD;
                phase_next       = pcp_pkg::PH_DISCARD;
                sig_match_next   = 1'b0;
            end
        endcase

        file_position_next   = file_position_next + 32'd1;
        result.signature_bad = !sig_match_next;
    end

    // Framing state advances once per processed item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= pcp_pkg::PH_SIG;
            field_index_reg    <= 3'd0;
            data_remaining_reg <= 32'd0;
            length_shift_reg   <= 32'd0;
            type_shift_reg     <= 32'd0;
            file_position_reg  <= 32'd0;
            start_offset_reg   <= 32'd0;
            sig_match_reg      <= 1'b1;
            target_seen_reg    <= 1'b0;
            target_active_reg  <= 1'b0;
        end else if (step) begin
            phase_reg          <= phase_next;
            field_index_reg    <= field_index_next;
            data_remaining_reg <= data_remaining_next;
            length_shift_reg   <= length_shift_next;
            type_shift_reg     <= type_shift_next;
            file_position_reg  <= file_position_next;
            start_offset_reg   <= start_offset_next;
            sig_match_reg      <= sig_match_next;
            target_seen_reg    <= target_seen_next;
            target_active_reg  <= target_active_next;
        end
    end

    // Target type register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_type_reg <= pcp_pkg::TARGET_RESET;
        end else if (cfg_wr_en) begin
            target_type_reg <= cfg_wr_data;
        end
    end

endmodule

// ===== design/png_chunk_stream_parser_unit.sv =====
// PNG chunk stream parser: one file byte in, one tagged result record out.
// Each item passes through the input register, the framing logic and the result register.
// Throughput is one item per cycle when the result side keeps up. Synchronous
// active-low reset empties both registers, returns to the signature phase and
// restores target "IDAT". Depends on pcp_pkg and pcp_framer.
module png_chunk_stream_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_byte_role,
    output logic        m_in_target,
    output logic        m_last_of_chunk,
    output logic        m_signature_ok,
    output logic        m_signature_bad,
    output logic [31:0] m_chunk_offset,
    output logic [31:0] m_chunk_length,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_first_reg;
    logic             out_valid_reg;
    pcp_pkg::result_t out_reg;
    pcp_pkg::result_t result;
    logic             out_free;
    logic             step;

    // Pipeline control: the result register frees on take, the input
    // register moves forward whenever the result register can load.
    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg  <= s_data_byte;
            in_first_reg <= s_first_byte;
        end
    end

    pcp_framer u_framer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .data_byte   (in_byte_reg),
        .first_byte  (in_first_reg),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .result      (result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_byte_role     = out_reg.byte_role;
    assign m_in_target     = out_reg.in_target;
    assign m_last_of_chunk = out_reg.last_of_chunk;
    assign m_signature_ok  = out_reg.signature_ok;
    assign m_signature_bad = out_reg.signature_bad;
    assign m_chunk_offset  = out_reg.chunk_offset;
    assign m_chunk_length  = out_reg.chunk_length;

endmodule
